[design/tls_sni_pkg.sv]
// ----------------------------------------------------------------------------
// tls_sni_pkg
// Shared types and constants of the ClientHello server-name extractor.
// ----------------------------------------------------------------------------
package tls_sni_pkg;

  typedef enum logic [3:0] {
    PH_START     = 4'd0,
    PH_HEADER    = 4'd1,
    PH_FIXED     = 4'd2,
    PH_SID_SKIP  = 4'd3,
    PH_CS_LEN    = 4'd4,
    PH_CS_SKIP   = 4'd5,
    PH_COMP_LEN  = 4'd6,
    PH_COMP_SKIP = 4'd7,
    PH_EXT_TOT   = 4'd8,
    PH_EXT_HDR   = 4'd9,
    PH_EXT_SKIP  = 4'd10,
    PH_SNI_HEAD  = 4'd11,
    PH_NAME      = 4'd12,
    PH_IDLE      = 4'd13
  } phase_t;

  // results caused by one input byte
  typedef struct packed {
    logic       cand;
    logic [7:0] host;
    logic       vd_valid;
    logic       verdict;
  } entry_t;

  localparam logic [7:0]  REC_TYPE_HS      = 8'h16;
  localparam logic [7:0]  HS_TYPE_CH       = 8'h01;
  localparam logic [15:0] EXT_TYPE_SNI     = 16'h0000;
  localparam logic [23:0] HS_MIN_LEN       = 24'd38;
  localparam int          REC_HDR_BYTES    = 5;
  localparam int          HDR_BYTES        = 5 + 4;
  localparam int          SID_LEN_OFFSET   = 34;
  localparam logic        KIND_HOST        = 1'b0;
  localparam logic        KIND_VERDICT     = 1'b1;
  localparam logic        VERDICT_FOUND    = 1'b0;
  localparam logic        VERDICT_NONE     = 1'b1;
  localparam int          QDEPTH           = 4;
  localparam int          QPTR_BITS        = 2;

  function automatic phase_t after_skip(input phase_t skip);
    phase_t r;
    unique case (skip)
      PH_SID_SKIP:  r = PH_CS_LEN;
      PH_CS_SKIP:   r = PH_COMP_LEN;
      PH_COMP_SKIP: r = PH_EXT_TOT;
      default:      r = PH_EXT_HDR;
    endcase
    return r;
  endfunction

endpackage

[design/tls_sni_front.sv]
// ----------------------------------------------------------------------------
// tls_sni_front
// Byte parser: walks record, handshake header and ClientHello body one byte
// per cycle while take is high; emits the results of each byte as one entry.
// ----------------------------------------------------------------------------
module tls_sni_front #(
  parameter int CW = 25
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic [7:0]          payload_byte,
  input  logic                segment_end,
  input  logic                flow_start,
  output logic                push,
  output tls_sni_pkg::entry_t push_entry
);

  localparam int OW = ((CW > 24) ? CW : 24) + 2;

  logic [CW-1:0]       fbc_r, c_fbc, n_fbc;
  logic [OW-1:0]       rec_exp_r, c_rec_exp, n_rec_exp;
  logic                rec_seen_r, c_rec_seen, n_rec_seen;
  logic                hs_seen_r, c_hs_seen, n_hs_seen;
  logic [23:0]         hs_len_r, c_hs_len, n_hs_len;
  tls_sni_pkg::phase_t phase_r, c_phase, n_phase;
  logic [15:0]         fr_r, c_fr, n_fr;
  logic [OW-1:0]       ext_end_r, c_ext_end, n_ext_end;
  logic [15:0]         nrem_r, c_nrem, n_nrem;
  logic [15:0]         sh_r, c_sh, n_sh;
  logic                found_r, c_found, n_found;
  logic                ign_r, c_ign, n_ign;
  tls_sni_pkg::entry_t ent;

  always_comb begin
    logic                stop;
    logic [OW-1:0]       b, len, off, ofs2;
    logic [15:0]         l;
    logic                req_skip, req_enter, req_loop;
    tls_sni_pkg::phase_t sk_kind, en_kind;
    logic [15:0]         sk_n;
    logic [OW-1:0]       sk_off, en_off, lp_off;

    if (flow_start) begin
      c_fbc = '0; c_rec_exp = '0; c_rec_seen = 1'b0; c_hs_seen = 1'b0;
      c_hs_len = '0; c_phase = tls_sni_pkg::PH_START; c_fr = '0;
      c_ext_end = '0; c_nrem = '0; c_sh = '0; c_found = 1'b0; c_ign = 1'b0;
    end else begin
      c_fbc = fbc_r; c_rec_exp = rec_exp_r; c_rec_seen = rec_seen_r;
      c_hs_seen = hs_seen_r; c_hs_len = hs_len_r; c_phase = phase_r;
      c_fr = fr_r; c_ext_end = ext_end_r; c_nrem = nrem_r; c_sh = sh_r;
      c_found = found_r; c_ign = ign_r;
    end
    n_fbc = c_fbc; n_rec_exp = c_rec_exp; n_rec_seen = c_rec_seen;
    n_hs_seen = c_hs_seen; n_hs_len = c_hs_len; n_phase = c_phase;
    n_fr = c_fr; n_ext_end = c_ext_end; n_nrem = c_nrem; n_sh = c_sh;
    n_found = c_found; n_ign = c_ign;

    stop = 1'b0;
    ent = '0;
    b = OW'(c_fbc) - OW'(tls_sni_pkg::HDR_BYTES);
    len = OW'(c_hs_len);
    off = '0; ofs2 = '0; l = '0;
    req_skip = 1'b0; req_enter = 1'b0; req_loop = 1'b0;
    sk_kind = tls_sni_pkg::PH_EXT_SKIP; en_kind = tls_sni_pkg::PH_EXT_HDR;
    sk_n = '0; sk_off = '0; en_off = '0; lp_off = '0;

    if (c_ign) begin
      stop = 1'b1;
    end else if (&c_fbc) begin
      n_ign = 1'b1;
      stop = 1'b1;
    end else begin
      n_fbc = c_fbc + CW'(1);
      if (c_fbc < CW'(tls_sni_pkg::HDR_BYTES)) begin
        if (c_fbc == CW'(0)) begin
          if (payload_byte != tls_sni_pkg::REC_TYPE_HS) begin
            n_ign = 1'b1;
            stop = 1'b1;
          end else begin
            n_phase = tls_sni_pkg::PH_HEADER;
          end
        end else if (c_fbc == CW'(3) || c_fbc == CW'(4)) begin
          n_sh = {c_sh[7:0], payload_byte};
        end else if (c_fbc == CW'(5)) begin
          n_rec_seen = 1'b1;
          n_rec_exp = OW'(tls_sni_pkg::REC_HDR_BYTES) + OW'(c_sh);
          if (payload_byte != tls_sni_pkg::HS_TYPE_CH) begin
            n_ign = 1'b1;
            stop = 1'b1;
          end
        end else if (c_fbc >= CW'(6)) begin
          n_hs_len = {c_hs_len[15:0], payload_byte};
          if (c_fbc == CW'(8)) begin
            n_hs_seen = 1'b1;
            n_rec_exp = OW'(tls_sni_pkg::HDR_BYTES) + OW'(n_hs_len);
            n_sh = '0;
            n_phase = (n_hs_len >= tls_sni_pkg::HS_MIN_LEN) ?
                      tls_sni_pkg::PH_FIXED : tls_sni_pkg::PH_IDLE;
          end
        end
        if (!stop && c_fbc < CW'(tls_sni_pkg::REC_HDR_BYTES) && segment_end) begin
          n_ign = 1'b1;
          stop = 1'b1;
        end
      end else begin
        unique case (c_phase)
          tls_sni_pkg::PH_FIXED: begin
            if (b == OW'(tls_sni_pkg::SID_LEN_OFFSET)) begin
              off = b + OW'(1) + OW'(payload_byte);
              if (off + OW'(2) > len) begin
                n_phase = tls_sni_pkg::PH_IDLE;
              end else begin
                req_skip = 1'b1; sk_kind = tls_sni_pkg::PH_SID_SKIP;
                sk_n = 16'(payload_byte); sk_off = off;
              end
            end
          end
          tls_sni_pkg::PH_CS_LEN: begin
            n_sh = {c_sh[7:0], payload_byte};
            n_fr = c_fr - 16'd1;
            if (n_fr == 16'd0) begin
              off = b + OW'(1) + OW'(n_sh);
              if (off >= len) begin
                n_phase = tls_sni_pkg::PH_IDLE;
              end else begin
                req_skip = 1'b1; sk_kind = tls_sni_pkg::PH_CS_SKIP;
                sk_n = n_sh; sk_off = off;
              end
            end
          end
          tls_sni_pkg::PH_COMP_LEN: begin
            off = b + OW'(1) + OW'(payload_byte);
            if (off + OW'(2) > len) begin
              n_phase = tls_sni_pkg::PH_IDLE;
            end else begin
              req_skip = 1'b1; sk_kind = tls_sni_pkg::PH_COMP_SKIP;
              sk_n = 16'(payload_byte); sk_off = off;
            end
          end
          tls_sni_pkg::PH_EXT_TOT: begin
            n_sh = {c_sh[7:0], payload_byte};
            n_fr = c_fr - 16'd1;
            if (n_fr == 16'd0) begin
              off = b + OW'(1);
              n_ext_end = off + OW'(n_sh);
              req_loop = 1'b1; lp_off = off;
            end
          end
          tls_sni_pkg::PH_EXT_HDR: begin
            // first two bytes: type, last two: length
            if (c_fr > 16'd2) n_nrem = {c_nrem[7:0], payload_byte};
            else              n_sh = {c_sh[7:0], payload_byte};
            n_fr = c_fr - 16'd1;
            if (n_fr == 16'd0) begin
              off = b + OW'(1);
              l = n_sh;
              if (n_nrem == tls_sni_pkg::EXT_TYPE_SNI && l >= 16'd5 &&
                  off + OW'(l) <= len) begin
                n_phase = tls_sni_pkg::PH_SNI_HEAD;
                n_fr = 16'd5;
                n_nrem = l;
                n_sh = '0;
              end else begin
                req_skip = 1'b1; sk_kind = tls_sni_pkg::PH_EXT_SKIP;
                sk_n = l; sk_off = off + OW'(l);
              end
            end
          end
          tls_sni_pkg::PH_SNI_HEAD: begin
            n_fr = c_fr - 16'd1;
            l = c_nrem;
            if (c_fr == 16'd3 && payload_byte != 8'd0) begin
              // name type other than host_name
              req_skip = 1'b1; sk_kind = tls_sni_pkg::PH_EXT_SKIP;
              sk_n = l - 16'd3; sk_off = b + OW'(1) + OW'(l - 16'd3);
            end else if (c_fr <= 16'd2) begin
              n_sh = {c_sh[7:0], payload_byte};
              if (c_fr == 16'd1) begin
                off = b + OW'(1);
                if (off + OW'(n_sh) <= len) begin
                  if (n_sh == 16'd0) begin
                    n_phase = tls_sni_pkg::PH_IDLE;
                  end else begin
                    n_found = 1'b1;
                    n_nrem = n_sh;
                    n_phase = tls_sni_pkg::PH_NAME;
                  end
                end else begin
                  req_skip = 1'b1; sk_kind = tls_sni_pkg::PH_EXT_SKIP;
                  sk_n = l - 16'd5; sk_off = off + OW'(l - 16'd5);
                end
              end
            end
          end
          tls_sni_pkg::PH_SID_SKIP, tls_sni_pkg::PH_CS_SKIP,
          tls_sni_pkg::PH_COMP_SKIP, tls_sni_pkg::PH_EXT_SKIP: begin
            n_fr = c_fr - 16'd1;
            if (n_fr == 16'd0) begin
              req_enter = 1'b1;
              en_kind = tls_sni_pkg::after_skip(c_phase);
              en_off = b + OW'(1);
            end
          end
          tls_sni_pkg::PH_NAME: begin
            n_nrem = c_nrem - 16'd1;
            if (n_nrem == 16'd0) n_phase = tls_sni_pkg::PH_IDLE;
            ent.cand = 1'b1;
            ent.host = payload_byte;
          end
          default: ;
        endcase

        if (req_skip) begin
          if (sk_n == 16'd0) begin
            req_enter = 1'b1;
            en_kind = tls_sni_pkg::after_skip(sk_kind);
            en_off = sk_off;
          end else begin
            n_phase = sk_kind;
            n_fr = sk_n;
          end
        end
        if (req_enter) begin
          n_sh = '0;
          unique case (en_kind)
            tls_sni_pkg::PH_CS_LEN: begin
              n_phase = tls_sni_pkg::PH_CS_LEN; n_fr = 16'd2;
            end
            tls_sni_pkg::PH_COMP_LEN: begin
              n_phase = tls_sni_pkg::PH_COMP_LEN; n_fr = 16'd1;
            end
            tls_sni_pkg::PH_EXT_TOT: begin
              n_phase = tls_sni_pkg::PH_EXT_TOT; n_fr = 16'd2;
            end
            default: begin
              req_loop = 1'b1; lp_off = en_off;
            end
          endcase
        end
        if (req_loop) begin
          ofs2 = lp_off + OW'(4);
          if (ofs2 <= n_ext_end && ofs2 <= len) begin
            n_phase = tls_sni_pkg::PH_EXT_HDR;
            n_fr = 16'd4;
            n_sh = '0;
            n_nrem = '0;
          end else begin
            n_phase = tls_sni_pkg::PH_IDLE;
          end
        end
      end
    end

    if (!stop && segment_end && n_rec_seen && n_hs_seen && OW'(n_fbc) == n_rec_exp) begin
      ent.vd_valid = 1'b1;
      ent.verdict = n_found ? tls_sni_pkg::VERDICT_FOUND : tls_sni_pkg::VERDICT_NONE;
      n_fbc = '0; n_rec_exp = '0; n_rec_seen = 1'b0; n_hs_seen = 1'b0;
      n_hs_len = '0; n_phase = tls_sni_pkg::PH_START; n_fr = '0;
      n_ext_end = '0; n_nrem = '0; n_sh = '0; n_found = 1'b0; n_ign = 1'b0;
    end
  end

  assign push       = take && (ent.cand || ent.vd_valid);
  assign push_entry = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fbc_r <= '0; rec_exp_r <= '0; rec_seen_r <= 1'b0; hs_seen_r <= 1'b0;
      hs_len_r <= '0; phase_r <= tls_sni_pkg::PH_START; fr_r <= '0;
      ext_end_r <= '0; nrem_r <= '0; sh_r <= '0; found_r <= 1'b0; ign_r <= 1'b0;
    end else if (take) begin
      fbc_r <= n_fbc; rec_exp_r <= n_rec_exp; rec_seen_r <= n_rec_seen;
      hs_seen_r <= n_hs_seen; hs_len_r <= n_hs_len; phase_r <= n_phase;
      fr_r <= n_fr; ext_end_r <= n_ext_end; nrem_r <= n_nrem; sh_r <= n_sh;
      found_r <= n_found; ign_r <= n_ign;
    end
  end

endmodule

[design/tls_sni_queue.sv]
// ----------------------------------------------------------------------------
// tls_sni_queue
// Short queue of result entries between parser and output stage.
// ----------------------------------------------------------------------------
module tls_sni_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tls_sni_pkg::entry_t push_entry,
  input  logic                pop,
  output logic                full,
  output logic                empty,
  output tls_sni_pkg::entry_t head
);

  localparam int PB = tls_sni_pkg::QPTR_BITS;

  tls_sni_pkg::entry_t       mem_r [tls_sni_pkg::QDEPTH];
  logic [PB-1:0]             wp_r, rp_r;
  logic [PB:0]               cnt_r;

  assign full  = (cnt_r == (PB+1)'(tls_sni_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + PB'(1);
      if (pop)  rp_r <= rp_r + PB'(1);
      cnt_r <= cnt_r + (PB+1)'(push) - (PB+1)'(pop);
    end
  end

endmodule

[design/tls_sni_back.sv]
// ----------------------------------------------------------------------------
// tls_sni_back
// Output stage: unpacks each queued entry into one or two result items.
// ----------------------------------------------------------------------------
module tls_sni_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                empty,
  input  tls_sni_pkg::entry_t head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_result_kind,
  output logic [7:0]          out_host_byte,
  output logic                out_verdict,
  output logic                out_last_of_run
);

  logic cand_sent_r;
  logic show_cand;

  // candidate goes first, verdict after it
  assign show_cand       = head.cand && !cand_sent_r;
  assign out_valid       = !empty;
  assign out_result_kind = show_cand ? tls_sni_pkg::KIND_HOST : tls_sni_pkg::KIND_VERDICT;
  assign out_host_byte   = show_cand ? head.host : 8'd0;
  assign out_verdict     = show_cand ? 1'b0 : head.verdict;
  assign out_last_of_run = !show_cand || !head.vd_valid;
  assign pop             = out_valid && out_ready && out_last_of_run;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_sent_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      cand_sent_r <= !out_last_of_run;
    end
  end

endmodule

[design/tls_client_hello_sni_extractor_top.sv]
// ----------------------------------------------------------------------------
// tls_client_hello_sni_extractor_top
// Streams the ClientHello server name of one TCP flow, byte by byte.
// ----------------------------------------------------------------------------
// Takes one payload byte per cycle and parses it in the cycle it is accepted;
// the results it causes (a host name byte, a verdict, or both) go into a
// four-entry queue, from which the output side sends one result item per
// cycle while out_ready is high. A byte that causes two results yields two
// items; input stalls only when the queue fills under output backpressure.
// The results of an accepted byte pass only through the queue registers
// on their way to the output. No clearing pass after reset.
module tls_client_hello_sni_extractor_top #(
  parameter int COUNT_BITS = 25
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_payload_byte,
  input  logic       in_segment_end,
  input  logic       in_flow_start,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_result_kind,
  output logic [7:0] out_host_byte,
  output logic       out_verdict,
  output logic       out_last_of_run
);

  logic                push, pop, full, empty;
  tls_sni_pkg::entry_t push_entry, head;

  assign in_ready = !full;

  tls_sni_front #(.CW(COUNT_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (in_valid && in_ready),
    .payload_byte (in_payload_byte),
    .segment_end  (in_segment_end),
    .flow_start   (in_flow_start),
    .push         (push),
    .push_entry   (push_entry)
  );

  tls_sni_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .empty      (empty),
    .head       (head)
  );

  tls_sni_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .empty           (empty),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_host_byte   (out_host_byte),
    .out_verdict     (out_verdict),
    .out_last_of_run (out_last_of_run)
  );

`ifndef SYNTH
  // a candidate that is not last is always followed by its verdict
  a_cand_then_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_run |=>
      out_valid && out_result_kind == tls_sni_pkg::KIND_VERDICT)
    else $error("verdict did not follow candidate");

  a_verdict_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == tls_sni_pkg::KIND_VERDICT |->
      out_host_byte == 8'd0 && out_last_of_run)
    else $error("bad verdict item");

  a_cand_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == tls_sni_pkg::KIND_HOST |-> !out_verdict)
    else $error("bad candidate item");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue overflow");
`endif

endmodule

[sim/tls_sni_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tls_sni_checker
// Watches both channels of the server-name extractor, predicts every result
// item from the accepted payload bytes and compares them field by field.
// ----------------------------------------------------------------------------
module tls_sni_checker #(
  parameter int COUNT_BITS = 25
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_payload_byte,
  input  logic       in_segment_end,
  input  logic       in_flow_start,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       out_result_kind,
  input  logic [7:0] out_host_byte,
  input  logic       out_verdict,
  input  logic       out_last_of_run,
  output int         fail_count,
  output int         pending
);

  typedef struct packed {
    logic       kind;
    logic [7:0] host;
    logic       vd;
    logic       last;
  } sni_result_t;

  sni_result_t exp_results[$];

  // flow context
  logic [63:0]         byte_cnt, rec_expected, ext_end;
  logic                rec_seen, hs_seen, name_found, ignored;
  logic [23:0]         hs_len;
  tls_sni_pkg::phase_t phase;
  logic [15:0]         fld_rem, name_rem, shadow;

  function automatic logic [63:0] cnt_max();
    return (64'd1 << COUNT_BITS) - 64'd1;
  endfunction

  function automatic void clear_ctx();
    byte_cnt = '0; rec_expected = '0; ext_end = '0;
    rec_seen = 1'b0; hs_seen = 1'b0; name_found = 1'b0; ignored = 1'b0;
    hs_len = '0; phase = tls_sni_pkg::PH_START; fld_rem = '0; name_rem = '0;
    shadow = '0;
  endfunction

  function automatic void ext_walk(input logic [63:0] off);
    if (off + 64'd4 <= ext_end && off + 64'd4 <= {40'd0, hs_len}) begin
      phase = tls_sni_pkg::PH_EXT_HDR; fld_rem = 16'd4; shadow = '0; name_rem = '0;
    end else begin
      phase = tls_sni_pkg::PH_IDLE;
    end
  endfunction

  function automatic void next_field(input tls_sni_pkg::phase_t nxt,
                                     input logic [63:0] off);
    shadow = '0;
    case (nxt)
      tls_sni_pkg::PH_CS_LEN: begin
        phase = tls_sni_pkg::PH_CS_LEN; fld_rem = 16'd2;
      end
      tls_sni_pkg::PH_COMP_LEN: begin
        phase = tls_sni_pkg::PH_COMP_LEN; fld_rem = 16'd1;
      end
      tls_sni_pkg::PH_EXT_TOT: begin
        phase = tls_sni_pkg::PH_EXT_TOT; fld_rem = 16'd2;
      end
      default: ext_walk(off);
    endcase
  endfunction

  function automatic tls_sni_pkg::phase_t skip_next(input tls_sni_pkg::phase_t s);
    case (s)
      tls_sni_pkg::PH_SID_SKIP:  return tls_sni_pkg::PH_CS_LEN;
      tls_sni_pkg::PH_CS_SKIP:   return tls_sni_pkg::PH_COMP_LEN;
      tls_sni_pkg::PH_COMP_SKIP: return tls_sni_pkg::PH_EXT_TOT;
      default:                   return tls_sni_pkg::PH_EXT_HDR;
    endcase
  endfunction

  function automatic void begin_skip(input tls_sni_pkg::phase_t s, input logic [31:0] n,
                                     input logic [63:0] off_after);
    if (n == 32'd0) next_field(skip_next(s), off_after);
    else begin
      phase = s; fld_rem = n[15:0];
    end
  endfunction

  // consumes one handshake body byte; returns 1 if it is a host name byte
  function automatic logic parse_body(input logic [63:0] b, input logic [7:0] v);
    logic [63:0] hl, off;
    logic [31:0] k, l, nl;
    hl = {40'd0, hs_len};
    case (phase)
      tls_sni_pkg::PH_FIXED: if (b == 64'(tls_sni_pkg::SID_LEN_OFFSET)) begin
        off = b + 64'd1 + 64'(v);
        if (off + 64'd2 > hl) phase = tls_sni_pkg::PH_IDLE;
        else begin_skip(tls_sni_pkg::PH_SID_SKIP, {24'd0, v}, off);
      end
      tls_sni_pkg::PH_CS_LEN: begin
        shadow = {shadow[7:0], v};
        fld_rem--;
        if (fld_rem == 16'd0) begin
          off = b + 64'd1 + 64'(shadow);
          if (off >= hl) phase = tls_sni_pkg::PH_IDLE;
          else begin_skip(tls_sni_pkg::PH_CS_SKIP, {16'd0, shadow}, off);
        end
      end
      tls_sni_pkg::PH_COMP_LEN: begin
        off = b + 64'd1 + 64'(v);
        if (off + 64'd2 > hl) phase = tls_sni_pkg::PH_IDLE;
        else begin_skip(tls_sni_pkg::PH_COMP_SKIP, {24'd0, v}, off);
      end
      tls_sni_pkg::PH_EXT_TOT: begin
        shadow = {shadow[7:0], v};
        fld_rem--;
        if (fld_rem == 16'd0) begin
          ext_end = b + 64'd1 + 64'(shadow);
          ext_walk(b + 64'd1);
        end
      end
      tls_sni_pkg::PH_EXT_HDR: begin
        k = 32'd4 - 32'(fld_rem);
        if (k < 32'd2) name_rem = {name_rem[7:0], v};
        else shadow = {shadow[7:0], v};
        fld_rem--;
        if (fld_rem == 16'd0) begin
          off = b + 64'd1;
          l = {16'd0, shadow};
          if (name_rem == tls_sni_pkg::EXT_TYPE_SNI && l >= 32'd5 &&
              off + 64'(l) <= hl) begin
            phase = tls_sni_pkg::PH_SNI_HEAD; fld_rem = 16'd5; name_rem = l[15:0];
            shadow = '0;
          end else begin
            begin_skip(tls_sni_pkg::PH_EXT_SKIP, l, off + 64'(l));
          end
        end
      end
      tls_sni_pkg::PH_SNI_HEAD: begin
        k = 32'd5 - 32'(fld_rem);
        fld_rem--;
        l = {16'd0, name_rem};
        if (k == 32'd2 && v != 8'd0) begin
          begin_skip(tls_sni_pkg::PH_EXT_SKIP, l - 32'd3, b + 64'd1 + 64'(l - 32'd3));
        end else if (k >= 32'd3) begin
          shadow = {shadow[7:0], v};
          if (k == 32'd4) begin
            nl = {16'd0, shadow};
            off = b + 64'd1;
            if (off + 64'(nl) <= hl) begin
              if (nl == 32'd0) phase = tls_sni_pkg::PH_IDLE;
              else begin
                name_found = 1'b1; name_rem = nl[15:0]; phase = tls_sni_pkg::PH_NAME;
              end
            end else begin
              begin_skip(tls_sni_pkg::PH_EXT_SKIP, l - 32'd5, off + 64'(l - 32'd5));
            end
          end
        end
      end
      tls_sni_pkg::PH_SID_SKIP, tls_sni_pkg::PH_CS_SKIP,
      tls_sni_pkg::PH_COMP_SKIP, tls_sni_pkg::PH_EXT_SKIP: begin
        fld_rem--;
        if (fld_rem == 16'd0) next_field(skip_next(phase), b + 64'd1);
      end
      tls_sni_pkg::PH_NAME: begin
        name_rem--;
        if (name_rem == 16'd0) phase = tls_sni_pkg::PH_IDLE;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  task automatic predict_byte(input logic [7:0] v, input logic seg, input logic fs);
    logic [63:0] i;
    sni_result_t r[2];
    int n;
    n = 0;
    if (fs) clear_ctx();
    if (ignored) return;
    if (byte_cnt >= cnt_max()) begin
      ignored = 1'b1;
      return;
    end
    i = byte_cnt;
    byte_cnt = i + 64'd1;
    if (i < 64'(tls_sni_pkg::HDR_BYTES)) begin
      if (i == 64'd0) begin
        if (v != tls_sni_pkg::REC_TYPE_HS) begin
          ignored = 1'b1;
          return;
        end
        phase = tls_sni_pkg::PH_HEADER;
      end else if (i == 64'd3 || i == 64'd4) begin
        shadow = {shadow[7:0], v};
      end else if (i == 64'd5) begin
        rec_seen = 1'b1;
        rec_expected = 64'(tls_sni_pkg::REC_HDR_BYTES) + 64'(shadow);
        if (v != tls_sni_pkg::HS_TYPE_CH) begin
          ignored = 1'b1;
          return;
        end
      end else if (i >= 64'd6) begin
        hs_len = {hs_len[15:0], v};
        if (i == 64'd8) begin
          hs_seen = 1'b1;
          rec_expected = 64'(tls_sni_pkg::HDR_BYTES) + 64'(hs_len);
          shadow = '0;
          phase = (hs_len >= tls_sni_pkg::HS_MIN_LEN) ?
                  tls_sni_pkg::PH_FIXED : tls_sni_pkg::PH_IDLE;
        end
      end
      if (i < 64'(tls_sni_pkg::REC_HDR_BYTES) && seg) begin
        ignored = 1'b1;
        return;
      end
    end else if (parse_body(i - 64'(tls_sni_pkg::HDR_BYTES), v)) begin
      r[n] = '{tls_sni_pkg::KIND_HOST, v, 1'b0, 1'b0};
      n++;
    end
    if (seg && rec_seen && hs_seen && byte_cnt == rec_expected) begin
      r[n] = '{tls_sni_pkg::KIND_VERDICT, 8'd0,
               name_found ? tls_sni_pkg::VERDICT_FOUND : tls_sni_pkg::VERDICT_NONE, 1'b0};
      n++;
      clear_ctx();
    end
    for (int j = 0; j < n; j++) begin
      r[j].last = (j == n - 1);
      exp_results.push_back(r[j]);
    end
  endtask

  task automatic report(input string what, input logic [11:0] got, input logic [11:0] want);
    $display("[%0t] mismatch %s: got %h expected %h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    sni_result_t w, g;
    if (!rst_n) begin
      clear_ctx();
      exp_results.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        g = '{out_result_kind, out_host_byte, out_verdict, out_last_of_run};
        if (exp_results.size() == 0) report("unexpected item", 12'(g), 12'd0);
        else begin
          w = exp_results.pop_front();
          if (g.kind != w.kind) report("result_kind", 12'(g.kind), 12'(w.kind));
          if (g.host != w.host) report("host_byte", 12'(g.host), 12'(w.host));
          if (g.vd != w.vd) report("verdict", 12'(g.vd), 12'(w.vd));
          if (g.last != w.last) report("last_of_run", 12'(g.last), 12'(w.last));
        end
      end
      if (in_valid && in_ready) predict_byte(in_payload_byte, in_segment_end, in_flow_start);
    end
    pending = exp_results.size();
  end

endmodule

[sim/tls_client_hello_sni_extractor_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tls_client_hello_sni_extractor_top_tb
// Feeds well-formed and broken ClientHello flows, with random idling on both
// channels and one long output hold-off; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tls_client_hello_sni_extractor_top_tb;

  localparam int WATCHDOG = 4000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_payload_byte;
  logic       in_segment_end;
  logic       in_flow_start;
  logic       out_valid;
  logic       out_ready;
  logic       out_result_kind;
  logic [7:0] out_host_byte;
  logic       out_verdict;
  logic       out_last_of_run;
  int         fail_count;
  int         pending;
  int         src_idle_pct;
  int         sink_stall_pct;
  logic       hold_off;
  int         quiet_cycles;
  int         bytes_sent;

  // staged flow bytes: {flow_start, segment_end, byte}
  logic [9:0] flow_buf[$];

  tls_client_hello_sni_extractor_top u_top (.*);

  tls_sni_checker u_chk (.*);

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // receiver
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !hold_off && ($urandom_range(99) >= sink_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG) begin
      $display("FAIL tls_client_hello_sni_extractor_top");
      $finish;
    end
  end

  // valid stays high from one accepted item to the next unless the sender idles
  task automatic send_byte(input logic [7:0] v, input logic seg, input logic fs);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_payload_byte <= v;
    in_segment_end <= seg;
    in_flow_start <= fs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic push(input logic [7:0] v);
    flow_buf.push_back({1'b0, 1'b0, v});
  endtask

  // builds a ClientHello; sni_mode 0 = good name, 1 = none, 2 = bad name type,
  // 3 = as 0, zero-length when name_len is 0, 4 = name overruns handshake
  task automatic build_hello(input int name_len, input int sni_mode, input int n_other);
    logic [7:0] body[$];
    int ext_len, hl, ncs, ncomp, sid, nfield;
    sid = $urandom_range(3);
    ncs = 2 * $urandom_range(1, 2);
    ncomp = $urandom_range(0, 2);
    body.delete();
    for (int i = 0; i < 34; i++) body.push_back(8'($urandom));
    body.push_back(8'(sid));
    for (int i = 0; i < sid; i++) body.push_back(8'($urandom));
    body.push_back(8'd0); body.push_back(8'(ncs));
    for (int i = 0; i < ncs; i++) body.push_back(8'($urandom));
    body.push_back(8'(ncomp));
    for (int i = 0; i < ncomp; i++) body.push_back(8'($urandom));
    ext_len = n_other * 5 + ((sni_mode == 1) ? 0 : 9 + name_len);
    body.push_back(8'(ext_len >> 8)); body.push_back(8'(ext_len));
    for (int e = 0; e < n_other; e++) begin
      body.push_back(8'h00); body.push_back(8'($urandom_range(1, 255)));
      body.push_back(8'd0); body.push_back(8'd1); body.push_back(8'($urandom));
    end
    if (sni_mode != 1) begin
      nfield = (sni_mode == 4) ? name_len + 40 : name_len;
      body.push_back(8'd0); body.push_back(8'd0);
      body.push_back(8'((name_len + 5) >> 8)); body.push_back(8'(name_len + 5));
      body.push_back(8'((name_len + 3) >> 8)); body.push_back(8'(name_len + 3));
      body.push_back(sni_mode == 2 ? 8'h01 : 8'h00);
      body.push_back(8'(nfield >> 8));
      body.push_back(8'(nfield));
      for (int i = 0; i < name_len; i++) body.push_back(8'($urandom_range(32, 255)));
    end
    hl = body.size();
    push(tls_sni_pkg::REC_TYPE_HS); push(8'h03); push(8'h01);
    push(8'((hl + 4) >> 8)); push(8'(hl + 4));
    push(tls_sni_pkg::HS_TYPE_CH); push(8'd0); push(8'(hl >> 8)); push(8'(hl));
    foreach (body[i]) push(body[i]);
  endtask

  // sends staged flow, split into random segments; mark_end ends the last one
  task automatic send_flow(input logic first_start, input logic mark_end);
    int cut;
    cut = $urandom_range(6, 40);
    for (int i = 0; i < flow_buf.size(); i++) begin
      logic seg;
      seg = (i == cut) || (mark_end && i == flow_buf.size() - 1);
      if (i == cut) cut = i + $urandom_range(1, 60);
      send_byte(flow_buf[i][7:0], seg, first_start && i == 0);
    end
    flow_buf.delete();
  endtask

  task automatic random_flow();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) build_hello($urandom_range(1, 12), 0, $urandom_range(0, 2));
    else if (pick < 62) build_hello(0, 1, $urandom_range(0, 2));
    else if (pick < 67) build_hello(4, 2, 0);
    else if (pick < 71) build_hello(0, 3, 1);
    else if (pick < 75) build_hello(3, 4, 0);
    else if (pick < 85) begin
      // short or garbled flow
      for (int i = 0; i < $urandom_range(1, 12); i++) push(8'($urandom));
      if ($urandom_range(1)) flow_buf[0][7:0] = tls_sni_pkg::REC_TYPE_HS;
    end else begin
      // short handshake
      push(tls_sni_pkg::REC_TYPE_HS); push(8'd3); push(8'd1); push(8'd0); push(8'd8);
      push(tls_sni_pkg::HS_TYPE_CH); push(8'd0); push(8'd0); push(8'd4);
      for (int i = 0; i < 4; i++) push(8'($urandom));
    end
    if ($urandom_range(9) == 0 && flow_buf.size() > 12) flow_buf.pop_back();
    send_flow($urandom_range(3) != 0, $urandom_range(9) != 0);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_payload_byte = 8'd0;
    in_segment_end = 1'b0;
    in_flow_start = 1'b0;
    hold_off = 1'b0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    bytes_sent = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: named, unnamed, non-handshake, truncated and non-ClientHello flows
    build_hello(1, 0, 0); send_flow(1, 1);
    build_hello(0, 1, 0); send_flow(1, 1);
    push(8'h17); push(8'hff); send_flow(1, 1);
    push(tls_sni_pkg::REC_TYPE_HS); push(8'h00); push(8'h80); send_flow(1, 1);
    push(tls_sni_pkg::REC_TYPE_HS); push(8'd3); push(8'd1); push(8'd0); push(8'd4);
    push(8'h02); push(8'd0); push(8'd0); push(8'd0); send_flow(1, 1);
    build_hello(2, 3, 0); send_flow(1, 1);

    // long hold-off on the output while input keeps coming
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        build_hello(12, 0, 0); send_flow(1, 1);
        in_valid <= 1'b0;
      end
    join

    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 33 : 52) : 0;
      sink_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 33 : 52) : 0;
      while (bytes_sent < 1050 * (ph + 1) / 4) random_flow();
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("PASS tls_client_hello_sni_extractor_top");
    else $display("FAIL tls_client_hello_sni_extractor_top");
    $finish;
  end

endmodule
